### rtl/floppy_disk_controller_switches_macros.svh
// Assertion macros used by the checker file.
`ifndef FLOPPY_DISK_CONTROLLER_SWITCHES_MACROS_SVH
`define FLOPPY_DISK_CONTROLLER_SWITCHES_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FDCS_ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FDCS_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### rtl/fdcs_pkg.sv
package fdcs_pkg;

    // Transaction kinds on the input channel
    localparam logic [2:0] ACT_SW_READ  = 3'd0;
    localparam logic [2:0] ACT_SW_WRITE = 3'd1;
    localparam logic [2:0] ACT_SEL_READ = 3'd2;
    localparam logic [2:0] ACT_SEL_WRITE = 3'd3;
    localparam logic [2:0] ACT_TICK     = 3'd4;

    // Soft switch offsets above the phase lines
    localparam logic [3:0] SW_MOTOR_OFF = 4'd8;
    localparam logic [3:0] SW_MOTOR_ON  = 4'd9;
    localparam logic [3:0] SW_UNIT_0    = 4'd10;
    localparam logic [3:0] SW_UNIT_1    = 4'd11;
    localparam logic [3:0] SW_Q6_OFF    = 4'd12;
    localparam logic [3:0] SW_Q6_ON     = 4'd13;
    localparam logic [3:0] SW_Q7_OFF    = 4'd14;
    localparam logic [3:0] SW_Q7_ON     = 4'd15;

    // Phase or command events toward the drives
    localparam logic [1:0] EVT_NONE   = 2'd0;
    localparam logic [1:0] EVT_PHASE  = 2'd1;
    localparam logic [1:0] EVT_STROBE = 2'd2;

    // Drive data operations
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_WRITE  = 2'd2;
    localparam logic [1:0] OP_STATUS = 2'd3;

    localparam logic [7:0] SPINDOWN_RESET = 8'd60;
    localparam logic [7:0] DATA_IDLE      = 8'hFF;
    localparam logic [7:0] HS_READY       = 8'hC0;
    localparam logic [7:0] HS_DONE        = 8'h80;
    localparam logic [6:0] MOTOR_LARGE    = 7'h50;
    localparam logic [6:0] MOTOR_SMALL    = 7'h60;
    localparam int         MODE_FAST_OFF  = 2;

    typedef struct packed {
        logic [7:0] read_data;
        logic [1:0] phase_event;
        logic [1:0] data_op;
        logic       drive_kind;
        logic       drive_unit;
        logic [3:0] drive_arg;
        logic [7:0] write_byte;
        logic       flush;
        logic [6:0] motor_state;
    } result_t;

endpackage

### rtl/floppy_disk_controller_switches.sv
// Register side of a floppy disk controller: decodes soft switch reads and
// writes, drive-select register reads and writes, and frame ticks, and
// reports one result per transaction (read data, phase or command events,
// drive data operations, flush request, motor state). A transaction is
// decoded and its state update applied in the cycle it is accepted; its
// result is registered into the result queue. One transaction per cycle is
// sustained while in_stall is low. Results sit in a two-entry queue, so
// input keeps flowing while one result waits; in_stall rises only when both
// queue entries are full. The user must write the spindown length through
// cfg_write_enable and cfg_write_data only while idle; it is not enforced.
module floppy_disk_controller_switches
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write_enable,
    input  logic [7:0] cfg_write_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] action,
    input  logic [3:0] offset,
    input  logic [7:0] write_data,
    input  logic [7:0] drive_read_data,
    input  logic       drive_status,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data,
    output logic [1:0] phase_event,
    output logic [1:0] data_op,
    output logic       drive_kind,
    output logic       drive_unit,
    output logic [3:0] drive_arg,
    output logic [7:0] write_byte,
    output logic       flush,
    output logic [6:0] motor_state
);

    // Controller state
    logic [7:0] spindown_frames_reg;
    logic [3:0] phase_reg,  phase_next;
    logic       motor_reg,  motor_next;
    logic       spin_reg,   spin_next;
    logic [7:0] left_reg,   left_next;
    logic       unit_reg,   unit_next;
    logic       q6_reg,     q6_next;
    logic       q7_reg,     q7_next;
    logic [4:0] mode_reg,   mode_next;
    logic       lsel_reg,   lsel_next;
    logic       lctl_reg,   lctl_next;
    logic       en2_reg,    en2_next;
    logic [1:0] hs_reg,     hs_next;

    // Result queue
    fdcs_pkg::result_t slot0_reg, slot0_next;
    fdcs_pkg::result_t slot1_reg, slot1_next;
    logic [1:0]        count_reg, count_next;
    fdcs_pkg::result_t res;

    logic       push;
    logic       pop;
    logic [1:0] ph_idx;
    logic       ph_on;
    logic       st;

    assign in_stall  = (count_reg == 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign push      = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;

    assign ph_idx = offset[2:1];
    assign ph_on  = offset[0];

    // Decode one transaction and work out the state that follows it
    always_comb
    begin
        phase_next = phase_reg;
        motor_next = motor_reg;
        spin_next  = spin_reg;
        left_next  = left_reg;
        unit_next  = unit_reg;
        q6_next    = q6_reg;
        q7_next    = q7_reg;
        mode_next  = mode_reg;
        lsel_next  = lsel_reg;
        lctl_next  = lctl_reg;
        en2_next   = en2_reg;
        hs_next    = hs_reg;
        res        = '0;
        st         = 1'b0;

        if (action == fdcs_pkg::ACT_SW_READ || action == fdcs_pkg::ACT_SW_WRITE)
        begin
            // Soft switch side effect, common to reads and writes
            if (!offset[3])
            begin
                phase_next[ph_idx] = ph_on;
                if (motor_reg)
                begin
                    if (lsel_reg)
                    begin
                        if (ph_idx == 2'd3 && ph_on)
                        begin
                            res.phase_event = fdcs_pkg::EVT_STROBE;
                            res.drive_kind  = 1'b1;
                            res.drive_arg   = {phase_next[1], phase_next[0],
                                               lctl_reg, phase_next[2]};
                        end
                    end
                    else if (ph_on)
                    begin
                        res.phase_event = fdcs_pkg::EVT_PHASE;
                        res.drive_kind  = 1'b0;
                        res.drive_arg   = {2'b00, ph_idx};
                    end
                end
                else
                begin
                    en2_next = phase_next[1] && phase_next[3];
                end
            end
            else
            begin
                unique case (offset)
                    fdcs_pkg::SW_MOTOR_OFF:
                    begin
                        if (mode_reg[fdcs_pkg::MODE_FAST_OFF])
                        begin
                            spin_next  = 1'b0;
                            motor_next = 1'b0;
                        end
                        else if (motor_reg && !spin_reg)
                        begin
                            spin_next = 1'b1;
                            left_next = spindown_frames_reg;
                        end
                    end
                    fdcs_pkg::SW_MOTOR_ON:
                    begin
                        motor_next = 1'b1;
                        spin_next  = 1'b0;
                    end
                    fdcs_pkg::SW_UNIT_0: unit_next = 1'b0;
                    fdcs_pkg::SW_UNIT_1: unit_next = 1'b1;
                    fdcs_pkg::SW_Q6_OFF: q6_next   = 1'b0;
                    fdcs_pkg::SW_Q6_ON:  q6_next   = 1'b1;
                    fdcs_pkg::SW_Q7_OFF: q7_next   = 1'b0;
                    default:             q7_next   = 1'b1;
                endcase
            end

            if (action == fdcs_pkg::ACT_SW_READ)
            begin
                // Odd switches read as zero
                if (!offset[0])
                begin
                    unique case ({q7_next, q6_next})
                        2'b00:
                        begin
                            if (en2_next || !motor_next)
                            begin
                                res.read_data = fdcs_pkg::DATA_IDLE;
                            end
                            else
                            begin
                                res.data_op    = fdcs_pkg::OP_READ;
                                res.drive_kind = lsel_reg;
                                res.read_data  = drive_read_data;
                            end
                        end
                        2'b01:
                        begin
                            if (en2_next)
                            begin
                                st = 1'b1;
                            end
                            else if (lsel_reg)
                            begin
                                if (motor_next)
                                begin
                                    res.data_op    = fdcs_pkg::OP_STATUS;
                                    res.drive_kind = 1'b1;
                                    res.drive_arg  = {phase_next[2], phase_next[1],
                                                      phase_next[0], lctl_reg};
                                    st = drive_status;
                                end
                                else
                                begin
                                    st = 1'b1;
                                end
                            end
                            else
                            begin
                                res.data_op    = fdcs_pkg::OP_STATUS;
                                res.drive_kind = 1'b0;
                                res.drive_arg  = 4'd0;
                                st = drive_status;
                            end
                            res.read_data = {st, 1'b0, motor_next, mode_reg};
                        end
                        2'b10:
                        begin
                            // Handshake register: wrap on the fourth read
                            if (!en2_next || hs_reg == 2'd3)
                            begin
                                res.read_data = fdcs_pkg::HS_DONE;
                                if (en2_next)
                                begin
                                    hs_next = 2'd0;
                                end
                            end
                            else
                            begin
                                res.read_data = fdcs_pkg::HS_READY;
                                hs_next = hs_reg + 2'd1;
                            end
                        end
                        default:
                        begin
                            res.read_data = 8'd0;
                        end
                    endcase
                end
            end
            else
            begin
                // Odd switch write with both latches set: data or mode load
                if (offset[0] && q7_next && q6_next)
                begin
                    if (motor_next)
                    begin
                        if (!en2_next)
                        begin
                            res.data_op    = fdcs_pkg::OP_WRITE;
                            res.drive_kind = lsel_reg;
                            res.write_byte = write_data;
                        end
                    end
                    else
                    begin
                        mode_next = write_data[4:0];
                    end
                end
            end
        end
        else if (action == fdcs_pkg::ACT_SEL_READ)
        begin
            res.read_data = {lctl_reg, lsel_reg, 6'd0};
        end
        else if (action == fdcs_pkg::ACT_SEL_WRITE)
        begin
            lctl_next = write_data[7];
            lsel_next = write_data[6];
        end
        else if (action == fdcs_pkg::ACT_TICK)
        begin
            // Advance the spindown countdown, stop the motor at its end
            if (motor_reg && spin_reg)
            begin
                if (left_reg <= 8'd1)
                begin
                    left_next  = 8'd0;
                    motor_next = 1'b0;
                    spin_next  = 1'b0;
                end
                else
                begin
                    left_next = left_reg - 8'd1;
                end
            end
            res.flush = !motor_next || spin_next;
        end

        // Drive addressing is only shown alongside an event or an operation
        if (res.phase_event != fdcs_pkg::EVT_NONE || res.data_op != fdcs_pkg::OP_NONE)
        begin
            res.drive_unit = unit_next;
        end
        else
        begin
            res.drive_kind = 1'b0;
        end
        res.motor_state = motor_next
                        ? ((lsel_next ? fdcs_pkg::MOTOR_LARGE : fdcs_pkg::MOTOR_SMALL)
                           | {6'd0, unit_next})
                        : 7'd0;
    end

    // Queue bookkeeping: head in slot 0, shift on pop
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            if (count_reg == 2'd0)
            begin
                slot0_next = res;
            end
            else
            begin
                slot1_next = res;
            end
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
        else if (pop && push)
        begin
            slot0_next = (count_reg == 2'd1) ? res : slot1_reg;
            slot1_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spindown_frames_reg <= fdcs_pkg::SPINDOWN_RESET;
            phase_reg <= 4'd0;
            motor_reg <= 1'b0;
            spin_reg  <= 1'b0;
            left_reg  <= 8'd0;
            unit_reg  <= 1'b0;
            q6_reg    <= 1'b0;
            q7_reg    <= 1'b0;
            mode_reg  <= 5'd0;
            lsel_reg  <= 1'b0;
            lctl_reg  <= 1'b0;
            en2_reg   <= 1'b0;
            hs_reg    <= 2'd0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (cfg_write_enable)
            begin
                spindown_frames_reg <= cfg_write_data;
            end
            // Commit the state update only for an accepted transaction
            if (push)
            begin
                phase_reg <= phase_next;
                motor_reg <= motor_next;
                spin_reg  <= spin_next;
                left_reg  <= left_next;
                unit_reg  <= unit_next;
                q6_reg    <= q6_next;
                q7_reg    <= q7_next;
                mode_reg  <= mode_next;
                lsel_reg  <= lsel_next;
                lctl_reg  <= lctl_next;
                en2_reg   <= en2_next;
                hs_reg    <= hs_next;
            end
            count_reg <= count_next;
        end
    end

    // Payload slots carry no reset
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign read_data   = slot0_reg.read_data;
    assign phase_event = slot0_reg.phase_event;
    assign data_op     = slot0_reg.data_op;
    assign drive_kind  = slot0_reg.drive_kind;
    assign drive_unit  = slot0_reg.drive_unit;
    assign drive_arg   = slot0_reg.drive_arg;
    assign write_byte  = slot0_reg.write_byte;
    assign flush       = slot0_reg.flush;
    assign motor_state = slot0_reg.motor_state;

endmodule

### rtl/fdcs_checker.sv
`include "floppy_disk_controller_switches_macros.svh"

module fdcs_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_write_enable,
    input logic [7:0] cfg_write_data,
    input logic       in_valid,
    input logic       in_stall,
    input logic [2:0] action,
    input logic [3:0] offset,
    input logic [7:0] write_data,
    input logic [7:0] drive_read_data,
    input logic       drive_status,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] read_data,
    input logic [1:0] phase_event,
    input logic [1:0] data_op,
    input logic       drive_kind,
    input logic       drive_unit,
    input logic [3:0] drive_arg,
    input logic [7:0] write_byte,
    input logic       flush,
    input logic [6:0] motor_state
);

    // Hold a stalled result
    `FDCS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(read_data) && $stable(motor_state), "stalled result changed")

    // Event kind matches the drive pair it addresses
    `FDCS_ASSERT_IMPLY(a_event_kind, clk, rst_n, out_valid && phase_event != fdcs_pkg::EVT_NONE, (phase_event == fdcs_pkg::EVT_STROBE) == drive_kind, "event kind mismatch")

    // Drop drive addressing when nothing goes to the drive
    `FDCS_ASSERT_IMPLY(a_idle_drive, clk, rst_n, out_valid && phase_event == fdcs_pkg::EVT_NONE && data_op == fdcs_pkg::OP_NONE, !drive_kind && !drive_unit && drive_arg == 4'd0 && write_byte == 8'd0, "drive fields set without event")

    // Motor state is either off or a valid pair code
    `FDCS_ASSERT_IMPLY(a_motor_code, clk, rst_n, out_valid, motor_state == 7'd0 || motor_state[6:1] == 6'h28 || motor_state[6:1] == 6'h30, "bad motor state")

endmodule

bind floppy_disk_controller_switches fdcs_checker u_fdcs_checker (.*);
